/* rtl/nv12_crop_resize_address_gen_defines.svh */
// assertion helpers shared by the address generator modules
// each macro expects clk and rst_n in scope
`ifndef NV12_CROP_RESIZE_ADDRESS_GEN_DEFINES_SVH
`define NV12_CROP_RESIZE_ADDRESS_GEN_DEFINES_SVH

// same-cycle implication
`define NV12CR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NV12CR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nv12cr_pkg.sv */
package nv12cr_pkg;

    // destination buffer size
    localparam int OUT_WIDTH  = 128;
    localparam int OUT_HEIGHT = 128;

    // derived sizes
    localparam int HALF_W  = OUT_WIDTH / 2;
    localparam int HALF_H  = OUT_HEIGHT / 2;
    localparam int CH_COLS = 2 * HALF_W;
    localparam int CH_ROWS = HALF_H;
    localparam int ROW_W   = $clog2(OUT_HEIGHT);
    localparam int COL_W   = $clog2(OUT_WIDTH);

    // field widths
    localparam int SIZE_W   = 14;
    localparam int STRIDE_W = 15;
    localparam int CROP_W   = 13;
    localparam int SRC_W    = 27;
    localparam int DST_W    = 14;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 15;

    // last destination byte of the chroma plane
    localparam int DST_LAST = (CH_ROWS - 1) * OUT_WIDTH + CH_COLS - 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOURCE_STRIDE = 3'd2;
    localparam logic [IDX_W-1:0] REG_CROP_X        = 3'd3;
    localparam logic [IDX_W-1:0] REG_CROP_Y        = 3'd4;
    localparam logic [IDX_W-1:0] REG_CROP_WIDTH    = 3'd5;
    localparam logic [IDX_W-1:0] REG_CROP_HEIGHT   = 3'd6;

    typedef struct packed {
        logic [SIZE_W-1:0]   source_width;
        logic [SIZE_W-1:0]   source_height;
        logic [STRIDE_W-1:0] source_stride;
        logic [CROP_W-1:0]   crop_x;
        logic [CROP_W-1:0]   crop_y;
        logic [SIZE_W-1:0]   crop_width;
        logic [SIZE_W-1:0]   crop_height;
    } cfg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_ADDR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scale;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

/* rtl/nv12cr_if.sv */
// request channel
interface nv12cr_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// result channel
interface nv12cr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          plane;
    logic [nv12cr_pkg::SRC_W-1:0]  src_offset;
    logic [nv12cr_pkg::DST_W-1:0]  dst_offset;
    logic                          last;

    modport source (output valid, output plane, output src_offset, output dst_offset,
                    output last, input ready);
    modport sink (input valid, input plane, input src_offset, input dst_offset,
                  input last, output ready);
endinterface

// register write channel
interface nv12cr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nv12cr_pkg::IDX_W-1:0]  index;
    logic [nv12cr_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/nv12cr_cfg.sv */
module nv12cr_cfg
(
    input  logic                 clk,
    input  logic                 rst_n,
    nv12cr_cfg_if.sink           cfg,
    output nv12cr_pkg::cfg_t     regs
);

    nv12cr_pkg::cfg_t regs_reg;
    nv12cr_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                nv12cr_pkg::REG_SOURCE_WIDTH:
                    regs_next.source_width = cfg.data[nv12cr_pkg::SIZE_W-1:0];
                nv12cr_pkg::REG_SOURCE_HEIGHT:
                    regs_next.source_height = cfg.data[nv12cr_pkg::SIZE_W-1:0];
                nv12cr_pkg::REG_SOURCE_STRIDE:
                    regs_next.source_stride = cfg.data[nv12cr_pkg::STRIDE_W-1:0];
                nv12cr_pkg::REG_CROP_X:
                    regs_next.crop_x = cfg.data[nv12cr_pkg::CROP_W-1:0];
                nv12cr_pkg::REG_CROP_Y:
                    regs_next.crop_y = cfg.data[nv12cr_pkg::CROP_W-1:0];
                nv12cr_pkg::REG_CROP_WIDTH:
                    regs_next.crop_width = cfg.data[nv12cr_pkg::SIZE_W-1:0];
                nv12cr_pkg::REG_CROP_HEIGHT:
                    regs_next.crop_height = cfg.data[nv12cr_pkg::SIZE_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    // register file with full-hd defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.source_width  <= 14'd1920;
            regs_reg.source_height <= 14'd1080;
            regs_reg.source_stride <= 15'd1920;
            regs_reg.crop_x        <= 13'd0;
            regs_reg.crop_y        <= 13'd0;
            regs_reg.crop_width    <= 14'd1920;
            regs_reg.crop_height   <= 14'd1080;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* rtl/nv12cr_ctrl.sv */
`include "nv12_crop_resize_address_gen_defines.svh"

module nv12cr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  nv12cr_pkg::sts_t   sts,
    output nv12cr_pkg::cmd_t   cmd
);

    nv12cr_pkg::state_t state_reg;
    nv12cr_pkg::state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nv12cr_pkg::S_IDLE:
                if (req_valid)
                begin
                    state_next = nv12cr_pkg::S_SCALE;
                end
            nv12cr_pkg::S_SCALE:
                state_next = nv12cr_pkg::S_ADDR;
            nv12cr_pkg::S_ADDR:
                if (sts.out_free)
                begin
                    state_next = nv12cr_pkg::S_IDLE;
                end
            default:
                state_next = nv12cr_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.scale  = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            nv12cr_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            nv12cr_pkg::S_SCALE:
                cmd.scale = 1'b1;
            nv12cr_pkg::S_ADDR:
                cmd.finish = sts.out_free;
            default:
                req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nv12cr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `NV12CR_ASSERT_NEXT(a_load_to_scale, cmd.load, state_reg == nv12cr_pkg::S_SCALE,
        "accepted item did not start scaling")
    `NV12CR_ASSERT_NEXT(a_scale_to_addr, cmd.scale, state_reg == nv12cr_pkg::S_ADDR,
        "scale step not followed by address step")
    `NV12CR_ASSERT_NEXT(a_addr_waits,
        state_reg == nv12cr_pkg::S_ADDR && !sts.out_free,
        state_reg == nv12cr_pkg::S_ADDR && !req_ready,
        "address step left while result register busy")

endmodule

/* rtl/nv12cr_dp.sv */
`include "nv12_crop_resize_address_gen_defines.svh"

module nv12cr_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  nv12cr_pkg::cfg_t   regs,
    input  nv12cr_pkg::cmd_t   cmd,
    output nv12cr_pkg::sts_t   sts,
    nv12cr_rsp_if.source       rsp
);

    localparam int ROW_W  = nv12cr_pkg::ROW_W;
    localparam int COL_W  = nv12cr_pkg::COL_W;
    localparam int SIZE_W = nv12cr_pkg::SIZE_W;
    localparam int YP_W   = ROW_W + SIZE_W;
    localparam int XP_W   = COL_W + SIZE_W;
    localparam int MUL_W  = SIZE_W + nv12cr_pkg::STRIDE_W;

    // frame position
    logic             plane_reg, plane_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // item being worked on
    logic             w_plane_reg;
    logic [ROW_W-1:0] w_row_reg;
    logic [COL_W-1:0] w_col_reg;
    logic             w_last_reg;

    // scaled source coordinates
    logic [SIZE_W-1:0] sy_reg, sy_next;
    logic [SIZE_W-1:0] sx_reg, sx_next;

    // result register
    logic                         out_valid_reg;
    logic                         out_plane_reg;
    logic [nv12cr_pkg::SRC_W-1:0] out_src_reg, out_src_next;
    logic [nv12cr_pkg::DST_W-1:0] out_dst_reg, out_dst_next;
    logic                         out_last_reg;

    logic             e_plane;
    logic [ROW_W-1:0] e_row;
    logic [COL_W-1:0] e_col;
    logic             last_next;

    // position of this item, then the step to the next one
    always_comb
    begin
        e_plane    = restart ? 1'b0 : plane_reg;
        e_row      = restart ? '0 : row_reg;
        e_col      = restart ? '0 : col_reg;
        plane_next = e_plane;
        row_next   = e_row;
        col_next   = e_col;
        last_next  = 1'b0;
        if ((32'(e_col) + 32'd1) <
            (e_plane ? 32'(nv12cr_pkg::CH_COLS) : 32'(nv12cr_pkg::OUT_WIDTH)))
        begin
            col_next = e_col + COL_W'(1);
        end
        else
        begin
            col_next = '0;
            if ((32'(e_row) + 32'd1) <
                (e_plane ? 32'(nv12cr_pkg::CH_ROWS) : 32'(nv12cr_pkg::OUT_HEIGHT)))
            begin
                row_next = e_row + ROW_W'(1);
            end
            else
            begin
                row_next   = '0;
                plane_next = ~e_plane;
                last_next  = e_plane;
            end
        end
    end

    logic [SIZE_W-1:0] y_mult, x_mult, y_size, x_size, y_lim, x_lim;
    logic [SIZE_W-1:0] y_base, x_base;
    logic [COL_W-1:0]  x_idx;
    logic [YP_W-1:0]   y_prod, y_quot;
    logic [XP_W-1:0]   x_prod, x_quot;
    logic [YP_W:0]     y_sum;
    logic [XP_W:0]     x_sum;

    // scale and clamp, halved window in chroma
    always_comb
    begin
        y_mult = w_plane_reg ? (regs.crop_height >> 1) : regs.crop_height;
        x_mult = w_plane_reg ? (regs.crop_width >> 1) : regs.crop_width;
        y_base = w_plane_reg ? SIZE_W'(regs.crop_y >> 1) : SIZE_W'(regs.crop_y);
        x_base = w_plane_reg ? SIZE_W'(regs.crop_x >> 1) : SIZE_W'(regs.crop_x);
        y_size = w_plane_reg ? (regs.source_height >> 1) : regs.source_height;
        x_size = w_plane_reg ? (regs.source_width >> 1) : regs.source_width;
        x_idx  = w_plane_reg ? (w_col_reg >> 1) : w_col_reg;
        y_prod = YP_W'(w_row_reg) * YP_W'(y_mult);
        x_prod = XP_W'(x_idx) * XP_W'(x_mult);
        y_quot = w_plane_reg ? (y_prod / YP_W'(nv12cr_pkg::HALF_H))
                             : (y_prod / YP_W'(nv12cr_pkg::OUT_HEIGHT));
        x_quot = w_plane_reg ? (x_prod / XP_W'(nv12cr_pkg::HALF_W))
                             : (x_prod / XP_W'(nv12cr_pkg::OUT_WIDTH));
        y_sum  = {1'b0, y_quot} + (YP_W + 1)'(y_base);
        x_sum  = {1'b0, x_quot} + (XP_W + 1)'(x_base);
        y_lim  = (y_size == '0) ? '0 : y_size - SIZE_W'(1);
        x_lim  = (x_size == '0) ? '0 : x_size - SIZE_W'(1);
        sy_next = (y_sum > (YP_W + 1)'(y_lim)) ? y_lim : y_sum[SIZE_W-1:0];
        sx_next = (x_sum > (XP_W + 1)'(x_lim)) ? x_lim : x_sum[SIZE_W-1:0];
    end

    logic [SIZE_W:0] x_term;
    logic [MUL_W-1:0] row_addr;

    // byte addresses; chroma samples are two bytes wide
    always_comb
    begin
        x_term       = w_plane_reg ? {sx_reg, w_col_reg[0]} : {1'b0, sx_reg};
        row_addr     = MUL_W'(sy_reg) * MUL_W'(regs.source_stride);
        out_src_next = nv12cr_pkg::SRC_W'(row_addr + MUL_W'(x_term));
        out_dst_next = nv12cr_pkg::DST_W'(32'(w_row_reg) * 32'(nv12cr_pkg::OUT_WIDTH)
                                          + 32'(w_col_reg));
    end

    assign sts.out_free = !out_valid_reg || rsp.ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg     <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                plane_reg <= plane_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_plane_reg <= e_plane;
            w_row_reg   <= e_row;
            w_col_reg   <= e_col;
            w_last_reg  <= last_next;
        end
        if (cmd.scale)
        begin
            sy_reg <= sy_next;
            sx_reg <= sx_next;
        end
        if (cmd.finish)
        begin
            out_plane_reg <= w_plane_reg;
            out_src_reg   <= out_src_next;
            out_dst_reg   <= out_dst_next;
            out_last_reg  <= w_last_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.plane      = out_plane_reg;
    assign rsp.src_offset = out_src_reg;
    assign rsp.dst_offset = out_dst_reg;
    assign rsp.last       = out_last_reg;

    `NV12CR_ASSERT_NEXT(a_restart_pos, cmd.load && restart,
        plane_reg == 1'b0 && row_reg == '0 && col_reg == COL_W'(1),
        "restart did not step past the first luma byte")
    `NV12CR_ASSERT_NOW(a_last_byte, out_valid_reg && out_last_reg,
        out_plane_reg && out_dst_reg == nv12cr_pkg::DST_W'(nv12cr_pkg::DST_LAST),
        "last flag away from the final chroma byte")
    `NV12CR_ASSERT_NOW(a_finish_free, cmd.finish, sts.out_free,
        "result written over an untaken result")

endmodule

/* rtl/nv12_crop_resize_address_gen.sv */
// Address generator for a nearest-neighbor crop and resize of an NV12 frame
// into a 128 x 128 NV12 buffer. Channel req carries one restart bit per item:
// 1 starts again at the first luma byte, 0 moves on to the next byte. Each
// item yields one item on rsp: plane, source byte offset, destination byte
// offset and a last flag on the final chroma byte of the frame, after which
// the walk wraps to luma. The cfg channel writes the seven window registers
// by index; it is always ready, and it must be used only while the block is
// idle, which the block itself does not enforce. One request at a time is
// carried through the accept, scale and address steps of the controller,
// with one multiplier stage in each of the last two, before the next is
// taken. The result register lets the next request be taken while a
// result still waits; if rsp stalls, the address step holds until the
// result register frees, and req is not ready in the meantime.
// Reset sets the registers to a 1920 x 1080 frame with a full-frame window
// and returns the walk to the first luma byte with no result pending.
module nv12_crop_resize_address_gen
(
    input logic        clk,
    input logic        rst_n,
    nv12cr_req_if.sink   req,
    nv12cr_rsp_if.source rsp,
    nv12cr_cfg_if.sink   cfg
);

    nv12cr_pkg::cfg_t regs;
    nv12cr_pkg::cmd_t cmd;
    nv12cr_pkg::sts_t sts;

    // window registers
    nv12cr_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // sequencing
    nv12cr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // address arithmetic and result register
    nv12cr_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (req.restart),
        .regs    (regs),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (rsp)
    );

endmodule
